// File: rtl/utcl_pkg.sv
// shared types, constants and calendar helpers for the utc to local date block
`timescale 1ns / 1ps
package utcl_pkg;

	localparam int YEAR_W   = 14;
	localparam int MONTH_W  = 4;
	localparam int DAY_W    = 5;
	localparam int HOUR_W   = 5;
	localparam int WDAY_W   = 3;
	localparam int OFFSET_W = 5;

	localparam logic [MONTH_W-1:0] MONTH_JAN = 4'd1;
	localparam logic [MONTH_W-1:0] MONTH_FEB = 4'd2;
	localparam logic [MONTH_W-1:0] MONTH_MAR = 4'd3;
	localparam logic [MONTH_W-1:0] MONTH_APR = 4'd4;
	localparam logic [MONTH_W-1:0] MONTH_JUN = 4'd6;
	localparam logic [MONTH_W-1:0] MONTH_SEP = 4'd9;
	localparam logic [MONTH_W-1:0] MONTH_NOV = 4'd11;
	localparam logic [MONTH_W-1:0] MONTH_DEC = 4'd12;

	localparam logic [DAY_W-1:0]  DAY_FIRST     = 5'd1;
	localparam logic [HOUR_W-1:0] HOURS_PER_DAY = 5'd24;
	localparam logic [WDAY_W-1:0] WDAY_LAST     = 3'd6;

	// floor(v / 25) = (v * RECIP25) >> RECIP25_SH, exact for v below 2^15
	localparam logic [15:0] RECIP25    = 16'd41944;
	localparam int          RECIP25_SH = 20;
	// floor(v / 7) = (v * RECIP7) >> RECIP7_SH, exact for v below 2^15
	localparam logic [15:0] RECIP7     = 16'd37450;
	localparam int          RECIP7_SH  = 18;

	typedef struct packed {
		logic [YEAR_W-1:0]  year;
		logic [MONTH_W-1:0] month;
		logic [DAY_W-1:0]   day;
		logic [HOUR_W-1:0]  hour;
	} date_t;

	function automatic logic [DAY_W-1:0] month_len(input logic [MONTH_W-1:0] m,
		input logic leap);
		logic [DAY_W-1:0] len;
		begin
			case (m)
				MONTH_FEB: len = leap ? 5'd29 : 5'd28;
				MONTH_APR, MONTH_JUN, MONTH_SEP, MONTH_NOV: len = 5'd30;
				default: len = 5'd31;
			endcase
			return len;
		end
	endfunction

	// floor(23 * m / 9)
	function automatic logic [5:0] month_term(input logic [MONTH_W-1:0] m);
		logic [5:0] t;
		begin
			case (m)
				4'd0:    t = 6'd0;
				4'd1:    t = 6'd2;
				4'd2:    t = 6'd5;
				4'd3:    t = 6'd7;
				4'd4:    t = 6'd10;
				4'd5:    t = 6'd12;
				4'd6:    t = 6'd15;
				4'd7:    t = 6'd17;
				4'd8:    t = 6'd20;
				4'd9:    t = 6'd23;
				4'd10:   t = 6'd25;
				4'd11:   t = 6'd28;
				4'd12:   t = 6'd30;
				4'd13:   t = 6'd33;
				4'd14:   t = 6'd35;
				4'd15:   t = 6'd38;
				default: t = 6'd0;
			endcase
			return t;
		end
	endfunction

endpackage

// File: rtl/utcl_date_adj.sv
// offset add, hour wrap and one-day date rollover, two pipeline stages
`timescale 1ns / 1ps
module utcl_date_adj (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 in_valid,
	input  utcl_pkg::date_t                      in_date,
	input  logic signed [utcl_pkg::OFFSET_W-1:0] offset,
	output logic                                 out_valid,
	output utcl_pkg::date_t                      out_date
);
	import utcl_pkg::*;

	// stage 1: hour sum, direction, year / 25
	logic signed [6:0] hour_sum;
	logic signed [6:0] hour_adj;
	logic              back;
	logic              fwd;
	logic [29:0]       y_prod;

	logic        v_s1;
	date_t       date_s1;
	logic        back_s1;
	logic        fwd_s1;
	logic [9:0]  q25_s1;

	assign hour_sum = $signed({2'b00, in_date.hour}) + $signed({{2{offset[4]}}, offset});
	assign back     = hour_sum[6];
	assign fwd      = !hour_sum[6] && (hour_sum >= $signed({2'b00, HOURS_PER_DAY}));
	assign y_prod   = 30'(in_date.year) * 30'(RECIP25);

	always_comb begin
		if (back) begin
			hour_adj = hour_sum + $signed({2'b00, HOURS_PER_DAY});
		end else if (fwd) begin
			hour_adj = hour_sum - $signed({2'b00, HOURS_PER_DAY});
		end else begin
			hour_adj = hour_sum;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else begin
			v_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		date_s1.year  <= in_date.year;
		date_s1.month <= in_date.month;
		date_s1.day   <= in_date.day;
		date_s1.hour  <= hour_adj[HOUR_W-1:0];
		back_s1       <= back;
		fwd_s1        <= fwd;
		q25_s1        <= y_prod[29:RECIP25_SH];
	end

	// stage 2: leap year, month length, rollover
	logic [YEAR_W-1:0]  rem25;
	logic               leap;
	logic [DAY_W-1:0]   len_cur;
	logic [DAY_W-1:0]   len_prev;
	logic [MONTH_W-1:0] month_prev;
	date_t              next_date;

	logic  v_s2;
	date_t date_s2;

	assign rem25      = date_s1.year - (14'(q25_s1) * 14'd25);
	// divisible by 4, and not by 100 unless also by 400 (400 = 16 * 25)
	assign leap       = (date_s1.year[1:0] == 2'b00)
		&& ((rem25 != '0) || (date_s1.year[3:0] == 4'b0000));
	assign month_prev = date_s1.month - 4'd1;
	assign len_cur    = month_len(date_s1.month, leap);
	assign len_prev   = month_len(month_prev, leap);

	always_comb begin
		next_date = date_s1;
		if (back_s1) begin
			if (date_s1.day <= DAY_FIRST) begin
				if (date_s1.month <= MONTH_JAN) begin
					next_date.year  = date_s1.year - 14'd1;
					next_date.month = MONTH_DEC;
					next_date.day   = month_len(MONTH_DEC, leap);
				end else begin
					next_date.month = month_prev;
					next_date.day   = len_prev;
				end
			end else begin
				next_date.day = date_s1.day - 5'd1;
			end
		end else if (fwd_s1) begin
			if (date_s1.day >= len_cur) begin
				if (date_s1.month >= MONTH_DEC) begin
					next_date.year  = date_s1.year + 14'd1;
					next_date.month = MONTH_JAN;
				end else begin
					next_date.month = date_s1.month + 4'd1;
				end
				next_date.day = DAY_FIRST;
			end else begin
				next_date.day = date_s1.day + 5'd1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else begin
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		date_s2 <= next_date;
	end

	assign out_valid = v_s2;
	assign out_date  = date_s2;

endmodule

// File: rtl/utcl_weekday.sv
// day of week of the local date, four pipeline stages
`timescale 1ns / 1ps
module utcl_weekday (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             in_valid,
	input  utcl_pkg::date_t                  in_date,
	output logic                             out_valid,
	output utcl_pkg::date_t                  out_date,
	output logic [utcl_pkg::WDAY_W-1:0]      out_wday
);
	import utcl_pkg::*;

	// stage 3: shifted year, base sum, century count product
	logic        early;
	logic [14:0] yy0;
	logic [14:0] yy;
	logic [14:0] base;
	logic [12:0] q4;
	logic [28:0] c_prod;

	logic        v_s3;
	date_t       date_s3;
	logic [14:0] base_s3;
	logic [12:0] q4_s3;
	logic [8:0]  q100_s3;

	// one 400-year cycle added keeps every term non-negative
	assign early  = in_date.month < MONTH_MAR;
	assign yy0    = 15'(in_date.year) + 15'd400;
	assign yy     = early ? (yy0 - 15'd1) : yy0;
	assign base   = 15'(month_term(in_date.month)) + 15'(in_date.day) + yy0 + 15'd4
		- (early ? 15'd0 : 15'd2);
	assign q4     = yy[14:2];
	assign c_prod = 29'(q4) * 29'(RECIP25);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s3 <= 1'b0;
		end else begin
			v_s3 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		date_s3 <= in_date;
		base_s3 <= base;
		q4_s3   <= q4;
		q100_s3 <= c_prod[28:RECIP25_SH];
	end

	// stage 4: full day count
	logic        v_s4;
	date_t       date_s4;
	logic [14:0] x_s4;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s4 <= 1'b0;
		end else begin
			v_s4 <= v_s3;
		end
	end

	always_ff @(posedge clk) begin
		date_s4 <= date_s3;
		x_s4    <= base_s3 + 15'(q4_s3) - 15'(q100_s3) + 15'(q100_s3[8:2]);
	end

	// stage 5: count / 7
	logic [30:0] w_prod;
	logic        v_s5;
	date_t       date_s5;
	logic [14:0] x_s5;
	logic [12:0] q7_s5;

	assign w_prod = 31'(x_s4) * 31'(RECIP7);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s5 <= 1'b0;
		end else begin
			v_s5 <= v_s4;
		end
	end

	always_ff @(posedge clk) begin
		date_s5 <= date_s4;
		x_s5    <= x_s4;
		q7_s5   <= w_prod[30:RECIP7_SH];
	end

	// stage 6: remainder
	logic [14:0]       rem7;
	logic              v_s6;
	date_t             date_s6;
	logic [WDAY_W-1:0] wday_s6;

	assign rem7 = x_s5 - (15'(q7_s5) * 15'd7);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s6 <= 1'b0;
		end else begin
			v_s6 <= v_s5;
		end
	end

	always_ff @(posedge clk) begin
		date_s6 <= date_s5;
		wday_s6 <= rem7[WDAY_W-1:0];
	end

	assign out_valid = v_s6;
	assign out_date  = date_s6;
	assign out_wday  = wday_s6;

endmodule

// File: rtl/utc_to_local_date_with_weekday_core.sv
// a result strobes on done once its start word has passed through the date rollover and weekday pipelines
// throughput: one date per cycle; busy stays low, the six-stage pipeline never stalls
// the depth is set by the three reciprocal multiplies (year / 25, year / 100, count / 7)
// reset: arst_n clears the pipeline valid bits and sets the zone offset to 0
// top level: zone offset register, date rollover and weekday pipelines
`timescale 1ns / 1ps
module utc_to_local_date_with_weekday_core (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 start,
	output logic                                 busy,
	input  logic [utcl_pkg::YEAR_W-1:0]          utc_year,
	input  logic [utcl_pkg::MONTH_W-1:0]         utc_month,
	input  logic [utcl_pkg::DAY_W-1:0]           utc_day,
	input  logic [utcl_pkg::HOUR_W-1:0]          utc_hour,
	input  logic                                 cfg_valid,
	output logic                                 cfg_ready,
	input  logic signed [utcl_pkg::OFFSET_W-1:0] cfg_data,
	output logic                                 done,
	output logic [utcl_pkg::YEAR_W-1:0]          local_year,
	output logic [utcl_pkg::MONTH_W-1:0]         local_month,
	output logic [utcl_pkg::DAY_W-1:0]           local_day,
	output logic [utcl_pkg::HOUR_W-1:0]          local_hour,
	output logic [utcl_pkg::WDAY_W-1:0]          weekday
);
	import utcl_pkg::*;

	logic signed [OFFSET_W-1:0] offset_q;
	date_t                      in_date;
	logic                       adj_valid;
	date_t                      adj_date;
	logic                       wd_valid;
	date_t                      wd_date;
	logic [WDAY_W-1:0]          wd_wday;

	assign busy      = 1'b0;
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			offset_q <= '0;
		end else if (cfg_valid && cfg_ready) begin
			offset_q <= cfg_data;
		end
	end

	assign in_date.year  = utc_year;
	assign in_date.month = utc_month;
	assign in_date.day   = utc_day;
	assign in_date.hour  = utc_hour;

	utcl_date_adj u_date_adj (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (start && !busy),
		.in_date   (in_date),
		.offset    (offset_q),
		.out_valid (adj_valid),
		.out_date  (adj_date)
	);

	utcl_weekday u_weekday (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (adj_valid),
		.in_date   (adj_date),
		.out_valid (wd_valid),
		.out_date  (wd_date),
		.out_wday  (wd_wday)
	);

	assign done        = wd_valid;
	assign local_year  = wd_date.year;
	assign local_month = wd_date.month;
	assign local_day   = wd_date.day;
	assign local_hour  = wd_date.hour;
	assign weekday     = wd_wday;

	a_hour_range: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (local_hour < HOURS_PER_DAY))
		else $error("local hour out of range");

	a_wday_range: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (weekday <= WDAY_LAST))
		else $error("weekday out of range");

	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(start, 6))
		else $error("result word without a matching start");

endmodule

// File: tb/utc_local_date_checker.sv
// checker for the utc to local date block: predicts every taken date word and compares each result
`timescale 1ns / 1ps
module utc_local_date_checker (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 start,
	input  logic                                 busy,
	input  logic [utcl_pkg::YEAR_W-1:0]          utc_year,
	input  logic [utcl_pkg::MONTH_W-1:0]         utc_month,
	input  logic [utcl_pkg::DAY_W-1:0]           utc_day,
	input  logic [utcl_pkg::HOUR_W-1:0]          utc_hour,
	input  logic                                 cfg_valid,
	input  logic                                 cfg_ready,
	input  logic signed [utcl_pkg::OFFSET_W-1:0] cfg_data,
	input  logic                                 done,
	input  logic [utcl_pkg::YEAR_W-1:0]          local_year,
	input  logic [utcl_pkg::MONTH_W-1:0]         local_month,
	input  logic [utcl_pkg::DAY_W-1:0]           local_day,
	input  logic [utcl_pkg::HOUR_W-1:0]          local_hour,
	input  logic [utcl_pkg::WDAY_W-1:0]          weekday,
	output int                                   fail_count,
	output int                                   pending
);

	localparam int REPORT_LIMIT = 10;

	typedef struct packed {
		logic [utcl_pkg::YEAR_W-1:0]  year;
		logic [utcl_pkg::MONTH_W-1:0] month;
		logic [utcl_pkg::DAY_W-1:0]   day;
		logic [utcl_pkg::HOUR_W-1:0]  hour;
		logic [utcl_pkg::WDAY_W-1:0]  wday;
	} local_date_t;

	local_date_t                         local_dates_due[$];
	logic signed [utcl_pkg::OFFSET_W-1:0] zone_offset;

	function automatic bit is_leap(input int unsigned y);
		return ((y % 4 == 0) && (y % 100 != 0)) || (y % 400 == 0);
	endfunction

	function automatic int unsigned days_in_month(input logic [utcl_pkg::MONTH_W-1:0] m,
		input int unsigned y);
		case (m)
			utcl_pkg::MONTH_FEB: return is_leap(y) ? 29 : 28;
			utcl_pkg::MONTH_APR, utcl_pkg::MONTH_JUN,
			utcl_pkg::MONTH_SEP, utcl_pkg::MONTH_NOV: return 30;
			default: return 31;
		endcase
	endfunction

	// proleptic gregorian, shifted one 400-year cycle so every term stays positive
	function automatic logic [utcl_pkg::WDAY_W-1:0] day_of_week(input int unsigned y,
		input int unsigned m, input int unsigned d);
		int unsigned yy;
		int unsigned dd;
		int unsigned w;
		yy = y + 400;
		if (m < 32'(utcl_pkg::MONTH_MAR)) begin
			dd = d + yy;
			yy = yy - 1;
		end else begin
			dd = d + yy - 2;
		end
		w = (23 * m / 9 + dd + 4 + yy / 4 - yy / 100 + yy / 400) % 7;
		return w[utcl_pkg::WDAY_W-1:0];
	endfunction

	function automatic local_date_t shift_to_local(input logic [utcl_pkg::YEAR_W-1:0] y,
		input logic [utcl_pkg::MONTH_W-1:0] m, input logic [utcl_pkg::DAY_W-1:0] d,
		input logic [utcl_pkg::HOUR_W-1:0] h, input logic signed [utcl_pkg::OFFSET_W-1:0] off);
		local_date_t r;
		int          sum;
		int unsigned yr;
		int unsigned mo;
		int unsigned dy;
		int unsigned hr;
		yr  = 32'(y);
		mo  = 32'(m);
		dy  = 32'(d);
		sum = int'(h) + int'(off);
		if (sum < 0) begin
			if (dy <= 1) begin
				if (mo <= 32'(utcl_pkg::MONTH_JAN)) begin
					yr = (yr - 1) & 32'h3fff;
					mo = 32'(utcl_pkg::MONTH_DEC);
				end else begin
					mo = mo - 1;
				end
				dy = days_in_month(mo[utcl_pkg::MONTH_W-1:0], yr);
			end else begin
				dy = dy - 1;
			end
			hr = sum + 24;
		end else if (sum >= 24) begin
			// a day at or past the month's end rolls over
			if (dy >= days_in_month(mo[utcl_pkg::MONTH_W-1:0], yr)) begin
				if (mo >= 32'(utcl_pkg::MONTH_DEC)) begin
					yr = (yr + 1) & 32'h3fff;
					mo = 32'(utcl_pkg::MONTH_JAN);
				end else begin
					mo = mo + 1;
				end
				dy = 32'(utcl_pkg::DAY_FIRST);
			end else begin
				dy = dy + 1;
			end
			hr = sum - 24;
		end else begin
			hr = sum;
		end
		r.year  = yr[utcl_pkg::YEAR_W-1:0];
		r.month = mo[utcl_pkg::MONTH_W-1:0];
		r.day   = dy[utcl_pkg::DAY_W-1:0];
		r.hour  = hr[utcl_pkg::HOUR_W-1:0];
		r.wday  = day_of_week(yr, mo, dy);
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		local_date_t want;
		local_date_t got;
		if (!arst_n) begin
			local_dates_due.delete();
			zone_offset <= '0;
			fail_count  = 0;
			pending     <= 0;
		end else begin
			if (done) begin
				got = '{local_year, local_month, local_day, local_hour, weekday};
				if (local_dates_due.size() == 0) begin
					fail_count++;
					if (fail_count <= REPORT_LIMIT)
						$display("unexpected result word: %0d-%0d-%0d hour %0d weekday %0d",
							got.year, got.month, got.day, got.hour, got.wday);
				end else begin
					want = local_dates_due.pop_front();
					if (got.year !== want.year || got.month !== want.month ||
						got.day !== want.day || got.hour !== want.hour ||
						got.wday !== want.wday) begin
						fail_count++;
						if (fail_count <= REPORT_LIMIT)
							$display("mismatch: expected %0d-%0d-%0d hour %0d weekday %0d,",
								want.year, want.month, want.day, want.hour, want.wday,
								" got %0d-%0d-%0d hour %0d weekday %0d",
								got.year, got.month, got.day, got.hour, got.wday);
					end
				end
			end
			if (start && !busy)
				local_dates_due.push_back(shift_to_local(utc_year, utc_month, utc_day,
					utc_hour, zone_offset));
			if (cfg_valid && cfg_ready)
				zone_offset <= cfg_data;
			pending <= local_dates_due.size();
		end
	end

endmodule

// File: tb/tb_utc_to_local_date_with_weekday_core.sv
// testbench top: clock, reset, date and zone offset stimulus, and the verdict
`timescale 1ns / 1ps
module tb_utc_to_local_date_with_weekday_core;

	localparam int PIPE_DEPTH  = 6;
	localparam int CYCLE_LIMIT = 300000;
	localparam int PHASE_ITEMS = 275;

	logic                                 clk = 1'b0;
	logic                                 arst_n;
	logic                                 start;
	logic                                 busy;
	logic [utcl_pkg::YEAR_W-1:0]          utc_year;
	logic [utcl_pkg::MONTH_W-1:0]         utc_month;
	logic [utcl_pkg::DAY_W-1:0]           utc_day;
	logic [utcl_pkg::HOUR_W-1:0]          utc_hour;
	logic                                 cfg_valid;
	logic                                 cfg_ready;
	logic signed [utcl_pkg::OFFSET_W-1:0] cfg_data;
	logic                                 done;
	logic [utcl_pkg::YEAR_W-1:0]          local_year;
	logic [utcl_pkg::MONTH_W-1:0]         local_month;
	logic [utcl_pkg::DAY_W-1:0]           local_day;
	logic [utcl_pkg::HOUR_W-1:0]          local_hour;
	logic [utcl_pkg::WDAY_W-1:0]          weekday;
	int                                   fail_count;
	int                                   pending;
	int                                   cycle_count = 0;
	bit                                   allow_gaps;
	int                                   phase_offsets[6];

	utc_to_local_date_with_weekday_core uut (.*);
	utc_local_date_checker chk (.*);

	always #4 clk = ~clk;

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("utc_to_local_date_with_weekday_core test failed");
			$finish;
		end
	end

	// called at a falling edge, returns at the falling edge after the word is taken
	// with start still high, so the caller decides what the next cycle carries
	task automatic send_date(input logic [utcl_pkg::YEAR_W-1:0] y,
		input logic [utcl_pkg::MONTH_W-1:0] m, input logic [utcl_pkg::DAY_W-1:0] d,
		input logic [utcl_pkg::HOUR_W-1:0] h);
		utc_year  = y;
		utc_month = m;
		utc_day   = d;
		utc_hour  = h;
		start     = 1'b1;
		@(posedge clk);
		while (busy) @(posedge clk);
		@(negedge clk);
	endtask

	task automatic idle_gap();
		if (allow_gaps && $urandom_range(0, 5) == 0) begin
			start = 1'b0;
			repeat ($urandom_range(1, 16)) @(negedge clk);
		end
	endtask

	task automatic drain();
		start = 1'b0;
		while (pending != 0) @(negedge clk);
	endtask

	task automatic write_offset(input logic signed [utcl_pkg::OFFSET_W-1:0] v);
		drain();
		cfg_valid = 1'b1;
		cfg_data  = v;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		@(negedge clk);
		cfg_valid = 1'b0;
	endtask

	task automatic send_random_date();
		logic [utcl_pkg::YEAR_W-1:0]  y;
		logic [utcl_pkg::MONTH_W-1:0] m;
		logic [utcl_pkg::DAY_W-1:0]   d;
		logic [utcl_pkg::HOUR_W-1:0]  h;
		logic [31:0]                  r;
		if ($urandom_range(0, 9) == 0) begin
			// raw bits: out of range months, days and hours
			r = $urandom;
			y = r[utcl_pkg::YEAR_W-1:0];
			m = r[17:14];
			d = r[22:18];
			h = r[27:23];
		end else begin
			case ($urandom_range(0, 3))
				0:       r = $urandom_range(0, 163) * 100;
				1:       r = $urandom_range(0, 16383);
				default: r = $urandom_range(1, 9999);
			endcase
			y = r[utcl_pkg::YEAR_W-1:0];
			r = $urandom_range(1, 12);
			m = r[utcl_pkg::MONTH_W-1:0];
			// month edges are where the rollover logic lives
			case ($urandom_range(0, 2))
				0:       r = 32'(utcl_pkg::DAY_FIRST);
				1:       r = $urandom_range(28, 31);
				default: r = $urandom_range(1, 31);
			endcase
			d = r[utcl_pkg::DAY_W-1:0];
			r = $urandom_range(0, 23);
			h = r[utcl_pkg::HOUR_W-1:0];
		end
		send_date(y, m, d, h);
	endtask

	initial begin
		arst_n     = 1'b0;
		start      = 1'b0;
		utc_year   = '0;
		utc_month  = '0;
		utc_day    = '0;
		utc_hour   = '0;
		cfg_valid  = 1'b0;
		cfg_data   = '0;
		allow_gaps = 1'b1;
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// offset zero from reset: pass through, hour above 23 and field extremes
		send_date(2024, 2, 29, 23);
		send_date(9999, 12, 31, 31);
		send_date(1, 1, 1, 0);
		send_date(0, 0, 0, 5);
		send_date(16383, 15, 31, 24);

		// most negative offset: back across months, years and year zero
		write_offset(-16);
		send_date(1, 1, 1, 0);
		send_date(0, 1, 1, 3);
		send_date(2000, 3, 1, 2);
		send_date(1900, 3, 1, 0);
		send_date(2023, 5, 1, 10);
		send_date(2023, 0, 1, 0);
		send_date(2023, 13, 0, 0);
		send_date(2024, 7, 15, 15);

		// most positive offset: forward across leap days and the year wrap
		write_offset(15);
		send_date(2023, 12, 31, 9);
		send_date(2024, 2, 28, 20);
		send_date(2023, 2, 28, 23);
		send_date(2100, 2, 28, 12);
		send_date(2023, 4, 30, 10);
		send_date(2023, 6, 31, 10);
		send_date(2023, 14, 31, 30);
		send_date(16383, 12, 31, 31);

		phase_offsets[0] = -12;
		phase_offsets[1] = 14;
		phase_offsets[2] = 0;
		phase_offsets[3] = $urandom_range(0, 31) - 16;
		phase_offsets[4] = -1;
		phase_offsets[5] = $urandom_range(0, 26) - 12;
		foreach (phase_offsets[p]) begin
			write_offset(phase_offsets[p][utcl_pkg::OFFSET_W-1:0]);
			allow_gaps = (p != 5);
			repeat (PHASE_ITEMS) begin
				send_random_date();
				idle_gap();
				if (allow_gaps && $urandom_range(0, 199) == 0)
					drain();
			end
		end

		drain();
		repeat (2 * PIPE_DEPTH) @(negedge clk);
		if (fail_count == 0 && pending == 0)
			$display("utc_to_local_date_with_weekday_core test passed");
		else
			$display("utc_to_local_date_with_weekday_core test failed");
		$finish;
	end

endmodule
